FILE: rtl/core/ipte_pkg.sv
// shared types, constants and defaults of the icon palette texel expander
// no dependencies; used by every core module and by the testbench

package ipte_pkg;

    // parameter defaults
    localparam int HEADER_BYTES_DEF = 512;
    localparam int MAX_FRAMES_DEF   = 3;
    localparam int TEX_WIDTH_DEF    = 64;

    // header layout and decode constants
    localparam logic [7:0]  MAGIC_0     = 8'h53;   // 'S'
    localparam logic [7:0]  MAGIC_1     = 8'h43;   // 'C'
    localparam logic [7:0]  FLAG_BASE   = 8'h10;
    localparam logic [9:0]  OFF_MAGIC_1 = 10'h001;
    localparam logic [9:0]  OFF_FLAG    = 10'h002;
    localparam logic [9:0]  OFF_PALETTE = 10'h060;
    localparam logic [9:0]  OFF_BITMAP  = 10'h080;
    localparam logic [9:0]  OFFSET_MAX  = 10'h3FF;
    localparam logic [15:0] COLOR_MASK  = 16'h7FFF;
    localparam logic [15:0] ALPHA_BIT   = 16'h8000;
    localparam logic [15:0] FILL_RESET  = 16'd40067;

    // parse phase
    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_ACTIVE = 2'd1,
        PH_DONE   = 2'd2
    } t_phase;

    // input request
    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] buffer_length;
    } t_in;

    // result request
    typedef struct packed {
        logic [15:0] texel_even;
        logic [15:0] texel_odd;
        logic [9:0]  texel_index;
        logic [1:0]  frame_count;
        logic        icon_ok;
        logic        end_of_icon;
    } t_out;

    // configuration request
    typedef struct packed {
        logic [15:0] transparent_fill;
    } t_cfg;

    // palette write port
    typedef struct packed {
        logic        en;
        logic [3:0]  addr;
        logic [15:0] data;
    } t_pal_wr;

    // parser result toward the output register
    typedef struct packed {
        logic has_result;
        t_out data;
    } t_res;

endpackage

FILE: rtl/core/ipte_chan_if.sv
// valid/ready channel carrying one request payload of type T
// depends on nothing; instantiated with the payload types of ipte_pkg

interface ipte_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/ipte_palette.sv
// 16-entry palette memory, one write port and two registered read ports
// depends on ipte_pkg for the write port struct

module ipte_palette (
    input  logic              i_clk,
    input  ipte_pkg::t_pal_wr i_wr,
    input  logic              i_rd_en,
    input  logic [3:0]        i_rd_addr_even,
    input  logic [3:0]        i_rd_addr_odd,
    output logic [15:0]       o_rd_even,
    output logic [15:0]       o_rd_odd
);

    logic [15:0] r_mem [16];
    logic [15:0] r_rd_even;
    logic [15:0] r_rd_odd;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.addr] <= i_wr.data;
        end
    end

    // read ports, forwarding a write to the same entry in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_even <= (i_wr.en && i_wr.addr == i_rd_addr_even) ? i_wr.data
                                                                  : r_mem[i_rd_addr_even];
            r_rd_odd  <= (i_wr.en && i_wr.addr == i_rd_addr_odd) ? i_wr.data
                                                                 : r_mem[i_rd_addr_odd];
        end
    end

    assign o_rd_even = r_rd_even;
    assign o_rd_odd  = r_rd_odd;

endmodule

FILE: rtl/core/ipte_parser.sv
// header parse state, palette word assembly and texel result forming
// depends on ipte_pkg; fed by the input register and the palette reads

module ipte_parser #(
    parameter int HEADER_BYTES = ipte_pkg::HEADER_BYTES_DEF,
    parameter int MAX_FRAMES   = ipte_pkg::MAX_FRAMES_DEF,
    parameter int TEX_WIDTH    = ipte_pkg::TEX_WIDTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_fire,
    input  ipte_pkg::t_in     i_req,
    input  logic [15:0]       i_pal_even,
    input  logic [15:0]       i_pal_odd,
    input  logic [15:0]       i_fill,
    output ipte_pkg::t_pal_wr o_pal_wr,
    output ipte_pkg::t_res    o_res
);

    ipte_pkg::t_phase r_phase, n_phase;
    logic [9:0]       r_offset, n_offset;
    logic [1:0]       r_frames, n_frames;
    logic [7:0]       r_latch, n_latch;

    logic [7:0]  w_d;
    logic        w_start_bad;
    logic        w_active;
    logic        w_flag_bad;
    logic        w_in_palette;
    logic        w_in_bitmap;
    logic [9:0]  w_adv;
    logic [9:0]  w_rel;
    logic [15:0] w_idx;
    logic [10:0] w_last;
    logic        w_is_last;
    logic [15:0] w_word;

    // shared decode
    assign w_d          = i_req.data_byte;
    assign w_start_bad  = (i_req.buffer_length < 16'(HEADER_BYTES)) || (w_d != ipte_pkg::MAGIC_0);
    assign w_active     = (r_phase == ipte_pkg::PH_ACTIVE);
    assign w_flag_bad   = (w_d < ipte_pkg::FLAG_BASE + 8'd1)
                       || (w_d > ipte_pkg::FLAG_BASE + 8'(MAX_FRAMES));
    assign w_in_palette = (r_offset >= ipte_pkg::OFF_PALETTE) && (r_offset < ipte_pkg::OFF_BITMAP);
    assign w_in_bitmap  = (r_offset >= ipte_pkg::OFF_BITMAP);
    assign w_adv        = (r_offset != ipte_pkg::OFFSET_MAX) ? r_offset + 10'd1 : r_offset;

    // bitmap placement: frame tiles of 16x16 laid left to right
    assign w_rel     = r_offset - ipte_pkg::OFF_BITMAP;
    assign w_idx     = 16'(w_rel[6:3]) * 16'(TEX_WIDTH) + 16'({w_rel[9:7], 4'b0000})
                     + 16'({w_rel[2:0], 1'b0});
    assign w_last    = 11'(ipte_pkg::OFF_BITMAP) + {2'b00, r_frames, 7'b0000000} - 11'd1;
    assign w_is_last = ({1'b0, r_offset} >= w_last);

    // palette word, zero maps to the transparent fill
    assign w_word = {w_d, r_latch};

    // next state
    always_comb begin
        n_phase  = r_phase;
        n_offset = r_offset;
        n_frames = r_frames;
        n_latch  = r_latch;
        if (i_req.first_byte) begin
            n_frames = 2'd0;
            if (w_start_bad) begin
                n_phase  = ipte_pkg::PH_DONE;
                n_offset = 10'd0;
            end else begin
                n_phase  = ipte_pkg::PH_ACTIVE;
                n_offset = 10'd1;
            end
        end else if (w_active) begin
            unique if (r_offset == ipte_pkg::OFF_MAGIC_1) begin
                if (w_d != ipte_pkg::MAGIC_1) begin
                    n_phase  = ipte_pkg::PH_DONE;
                    n_frames = 2'd0;
                end else begin
                    n_offset = w_adv;
                end
            end else if (r_offset == ipte_pkg::OFF_FLAG) begin
                if (w_flag_bad) begin
                    n_phase  = ipte_pkg::PH_DONE;
                    n_frames = 2'd0;
                end else begin
                    n_frames = 2'(w_d - ipte_pkg::FLAG_BASE);
                    n_offset = w_adv;
                end
            end else if (w_in_palette) begin
                if (!r_offset[0]) begin
                    n_latch = w_d;
                end
                n_offset = w_adv;
            end else if (w_in_bitmap) begin
                if (w_is_last) begin
                    n_phase = ipte_pkg::PH_DONE;
                end else begin
                    n_offset = w_adv;
                end
            end else begin
                n_offset = w_adv;
            end
        end
    end

    // outputs: palette write and result
    always_comb begin
        o_pal_wr      = '0;
        o_res         = '0;
        o_pal_wr.addr = r_offset[4:1];
        o_pal_wr.data = (w_word == 16'd0) ? i_fill
                                          : ((w_word & ipte_pkg::COLOR_MASK) | ipte_pkg::ALPHA_BIT);
        if (i_req.first_byte) begin
            if (w_start_bad) begin
                o_res.has_result       = 1'b1;
                o_res.data.end_of_icon = 1'b1;
            end
        end else if (w_active) begin
            unique if (r_offset == ipte_pkg::OFF_MAGIC_1) begin
                if (w_d != ipte_pkg::MAGIC_1) begin
                    o_res.has_result       = 1'b1;
                    o_res.data.end_of_icon = 1'b1;
                end
            end else if (r_offset == ipte_pkg::OFF_FLAG) begin
                if (w_flag_bad) begin
                    o_res.has_result       = 1'b1;
                    o_res.data.end_of_icon = 1'b1;
                end
            end else if (w_in_palette) begin
                // write only when the byte actually moves on
                o_pal_wr.en = i_fire && r_offset[0];
            end else if (w_in_bitmap) begin
                o_res.has_result       = 1'b1;
                o_res.data.texel_even  = i_pal_even;
                o_res.data.texel_odd   = i_pal_odd;
                o_res.data.texel_index = w_idx[9:0];
                o_res.data.frame_count = r_frames;
                o_res.data.icon_ok     = 1'b1;
                o_res.data.end_of_icon = w_is_last;
            end else begin
                o_res.has_result = 1'b0;
            end
        end
    end

    // parse state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= ipte_pkg::PH_IDLE;
            r_offset <= 10'd0;
            r_frames <= 2'd0;
            r_latch  <= 8'd0;
        end else if (i_fire) begin
            r_phase  <= n_phase;
            r_offset <= n_offset;
            r_frames <= n_frames;
            r_latch  <= n_latch;
        end
    end

    // a reject carries no frames and always closes the buffer
    a_reject_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.has_result && !o_res.data.icon_ok
        |-> o_res.data.end_of_icon && o_res.data.frame_count == 2'd0)
        else $error("reject result malformed");

    // texel results only come with a nonzero frame count
    a_texel_frames: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.has_result && o_res.data.icon_ok |-> o_res.data.frame_count != 2'd0)
        else $error("texel result without frames");

    // palette writes and results never share a byte
    a_wr_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_pal_wr.en |-> !o_res.has_result)
        else $error("palette write with result");

    // the last result of a buffer leaves the parse finished
    a_end_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && o_res.has_result && o_res.data.end_of_icon |=> r_phase == ipte_pkg::PH_DONE)
        else $error("parse still active after end of icon");

endmodule

FILE: rtl/core/icon_palette_texel_expander_core.sv
// top level of the icon palette texel expander: input register, parser,
// palette memory, result register and the transparent fill register
// depends on ipte_pkg, ipte_chan_if, ipte_palette and ipte_parser
//
// Usage:
//   i_in carries one header byte per request with first_byte marking
//   offset zero of a buffer and buffer_length checked on that byte.
//   o_out carries zero or one result per byte: a texel pair with its
//   texture index, or a reject, end_of_icon marking the last of a buffer.
//   i_cfg writes the transparent fill register; it is always ready.
//   Throughput: one byte per cycle while o_out is taken. A byte is held
//   in the input register while its palette entries are read, then the
//   parser fills the result register once that register is free or
//   draining, and the result is then valid on o_out. The palette read is
//   registered alongside the input register.
//   When the receiver stalls, the pending result holds in the result
//   register and one further byte is taken into the input register;
//   i_in.ready then drops until the result is taken.
//   Reset clears the parse state, both valid flags and sets the fill to
//   40067; the palette holds garbage until a header writes it.

module icon_palette_texel_expander_core #(
    parameter int HEADER_BYTES = ipte_pkg::HEADER_BYTES_DEF,
    parameter int MAX_FRAMES   = ipte_pkg::MAX_FRAMES_DEF,
    parameter int TEX_WIDTH    = ipte_pkg::TEX_WIDTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    ipte_chan_if.sink    i_in,
    ipte_chan_if.source  o_out,
    ipte_chan_if.sink    i_cfg
);

    logic              r_in_valid;
    ipte_pkg::t_in     r_in;
    logic              r_out_valid;
    ipte_pkg::t_out    r_out;
    logic [15:0]       r_fill;

    logic              w_accept;
    logic              w_fire;
    ipte_pkg::t_in     w_req;
    logic [15:0]       w_pal_even;
    logic [15:0]       w_pal_odd;
    ipte_pkg::t_pal_wr w_pal_wr;
    ipte_pkg::t_res    w_res;

    // handshake: the stage advances when the result register is free or draining
    assign w_fire      = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready  = !r_in_valid || w_fire;
    assign w_accept    = i_in.valid && i_in.ready;
    assign w_req       = i_in.data;
    assign i_cfg.ready = 1'b1;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_accept) begin
            r_in_valid <= 1'b1;
        end else if (w_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in <= w_req;
        end
    end

    // transparent fill register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= ipte_pkg::FILL_RESET;
        end else if (i_cfg.valid) begin
            r_fill <= i_cfg.data.transparent_fill;
        end
    end

    // palette lookup for both nibbles of the incoming byte
    ipte_palette u_palette (
        .i_clk          (i_clk),
        .i_wr           (w_pal_wr),
        .i_rd_en        (w_accept),
        .i_rd_addr_even (w_req.data_byte[3:0]),
        .i_rd_addr_odd  (w_req.data_byte[7:4]),
        .o_rd_even      (w_pal_even),
        .o_rd_odd       (w_pal_odd)
    );

    // header parse and texel forming
    ipte_parser #(
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_FRAMES   (MAX_FRAMES),
        .TEX_WIDTH    (TEX_WIDTH)
    ) u_parser (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (w_fire),
        .i_req      (r_in),
        .i_pal_even (w_pal_even),
        .i_pal_odd  (w_pal_odd),
        .i_fill     (r_fill),
        .o_pal_wr   (w_pal_wr),
        .o_res      (w_res)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fire && w_res.has_result) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_res.has_result) begin
            r_out <= w_res.data;
        end
    end

    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;

    // a byte only moves on when its result has somewhere to go
    a_fire_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fire |-> !r_out_valid || o_out.ready)
        else $error("stage advanced into a full result register");

    // an accepted byte is held until it is processed
    a_in_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_in_valid)
        else $error("accepted byte lost");

    // a stalled result is not overwritten
    a_out_kept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !o_out.ready |=> r_out_valid && $stable(r_out))
        else $error("pending result overwritten");

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// self-checking testbench for icon_palette_texel_expander_core: header bytes in, texel pairs out
// depends on ipte_pkg, ipte_chan_if and the core; carries its own decoder to predict each result

module testbench;

    localparam int HDR_BYTES   = ipte_pkg::HEADER_BYTES_DEF;
    localparam int FRAMES_MAX  = ipte_pkg::MAX_FRAMES_DEF;
    localparam int TEX_W       = ipte_pkg::TEX_WIDTH_DEF;
    localparam int FRAME_SIZE  = 128;
    localparam int SETTLE      = 4;
    localparam int HOLD_CYCLES = 300;
    localparam int ITEM_TARGET = 1450;

    localparam ipte_pkg::t_out REJECT_RES = '{16'h0000, 16'h0000, 10'd0, 2'd0, 1'b0, 1'b1};

    typedef enum logic [1:0] {
        ROW_BYTE = 2'd0,
        ROW_ICON = 2'd1,
        ROW_FILL = 2'd2
    } t_row_kind;

    typedef enum logic [1:0] {
        PAL_RANDOM = 2'd0,
        PAL_ZERO   = 2'd1,
        PAL_ONES   = 2'd2,
        PAL_MIX    = 2'd3
    } t_pal_mode;

    // how the expectation of a request is obtained
    typedef enum logic [1:0] {
        W_PRED   = 2'd0,
        W_NONE   = 2'd1,
        W_REJECT = 2'd2
    } t_want;

    // one directed step: a single byte, a whole header, or a fill write (value in len)
    typedef struct packed {
        t_row_kind   kind;
        logic [7:0]  d;
        logic        first;
        logic [15:0] len;
        t_pal_mode   pal;
        logic [9:0]  stop;
        logic [3:0]  tail;
        t_want       want;
    } t_row;

    localparam int NROWS = 21;

    t_row plan [0:NROWS-1] = '{
        '{ROW_BYTE, 8'h00,             1'b0, 16'h0000, PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, 8'hFF,             1'b0, 16'hFFFF, PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, ipte_pkg::MAGIC_0, 1'b1, 16'd511,  PAL_RANDOM, 10'd0, 4'd0, W_REJECT},
        '{ROW_BYTE, ipte_pkg::MAGIC_1, 1'b0, 16'h0000, PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, ipte_pkg::MAGIC_0, 1'b1, 16'h0000, PAL_RANDOM, 10'd0, 4'd0, W_REJECT},
        '{ROW_BYTE, 8'h00,             1'b1, 16'hFFFF, PAL_RANDOM, 10'd0, 4'd0, W_REJECT},
        '{ROW_BYTE, ipte_pkg::MAGIC_0, 1'b1, 16'd512,  PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, ipte_pkg::MAGIC_0, 1'b0, 16'h0000, PAL_RANDOM, 10'd0, 4'd0, W_REJECT},
        '{ROW_BYTE, ipte_pkg::MAGIC_0, 1'b1, 16'd512,  PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, ipte_pkg::MAGIC_1, 1'b0, 16'h0000, PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, 8'h10,             1'b0, 16'h0000, PAL_RANDOM, 10'd0, 4'd0, W_REJECT},
        '{ROW_BYTE, ipte_pkg::MAGIC_0, 1'b1, 16'hFFFF, PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, ipte_pkg::MAGIC_1, 1'b0, 16'hFFFF, PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, 8'h14,             1'b0, 16'hFFFF, PAL_RANDOM, 10'd0, 4'd0, W_REJECT},
        '{ROW_BYTE, ipte_pkg::MAGIC_0, 1'b1, 16'd512,  PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, ipte_pkg::MAGIC_1, 1'b0, 16'h5555, PAL_RANDOM, 10'd0, 4'd0, W_NONE},
        '{ROW_BYTE, 8'hFF,             1'b0, 16'hAAAA, PAL_RANDOM, 10'd0, 4'd0, W_REJECT},
        // one frame cut short in the bitmap, zero words take the fill left by reset
        '{ROW_ICON, 8'h11,             1'b1, 16'd512,  PAL_ZERO,   10'd140, 4'd0, W_PRED},
        '{ROW_FILL, 8'h00,             1'b0, 16'hFFFF, PAL_RANDOM, 10'd0, 4'd0, W_PRED},
        // next header restarts; all frames, trailing bytes after the last pair are dropped
        '{ROW_ICON, 8'h13,             1'b1, 16'hFFFF, PAL_MIX,    10'd0, 4'd6, W_PRED},
        '{ROW_FILL, 8'h00,             1'b0, 16'h0000, PAL_RANDOM, 10'd0, 4'd0, W_PRED}
    };

    logic i_clk = 1'b0;
    logic i_rst_n;

    ipte_chan_if #(.T(ipte_pkg::t_in))  in_ch  ();
    ipte_chan_if #(.T(ipte_pkg::t_out)) out_ch ();
    ipte_chan_if #(.T(ipte_pkg::t_cfg)) cfg_ch ();

    icon_palette_texel_expander_core u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always #5 i_clk = ~i_clk;

    // decoder copy of the block state
    logic [15:0]      fill_shadow = ipte_pkg::FILL_RESET;
    logic [9:0]       hdr_offset  = '0;
    ipte_pkg::t_phase hdr_phase   = ipte_pkg::PH_IDLE;
    logic [1:0]       hdr_frames  = '0;
    logic [15:0]      clut [16];
    logic [7:0]       clut_low    = '0;

    ipte_pkg::t_out icon_results_due [$];
    int   mismatch_count = 0;
    int   bytes_sent     = 0;
    bit   steady         = 1'b0;
    bit   hold_out       = 1'b0;

    function automatic int pick_wait();
        if (steady)
            return 0;
        return $urandom_range(0, 14);
    endfunction

    // decode one accepted header byte, returning the texel pair or reject it causes
    function automatic void decode_header_byte(input ipte_pkg::t_in it, output bit has,
                                               output ipte_pkg::t_out res);
        logic [9:0]  rel;
        logic [15:0] word;
        logic [3:0]  slot;
        int          idx;
        int          last_off;
        bit          rejected;
        has      = 1'b0;
        res      = '0;
        rejected = 1'b0;
        if (it.first_byte) begin
            hdr_offset = '0;
            hdr_frames = '0;
            hdr_phase  = ipte_pkg::PH_ACTIVE;
            if (it.buffer_length < HDR_BYTES || it.data_byte != ipte_pkg::MAGIC_0) begin
                has       = 1'b1;
                res       = REJECT_RES;
                hdr_phase = ipte_pkg::PH_DONE;
            end else begin
                hdr_offset = ipte_pkg::OFF_MAGIC_1;
            end
            return;
        end
        if (hdr_phase != ipte_pkg::PH_ACTIVE)
            return;

        if (hdr_offset == ipte_pkg::OFF_MAGIC_1) begin
            rejected = (it.data_byte != ipte_pkg::MAGIC_1);
        end else if (hdr_offset == ipte_pkg::OFF_FLAG) begin
            if (it.data_byte < ipte_pkg::FLAG_BASE + 8'd1
                || it.data_byte > ipte_pkg::FLAG_BASE + FRAMES_MAX)
                rejected = 1'b1;
            else
                hdr_frames = 2'(it.data_byte - ipte_pkg::FLAG_BASE);
        end else if (hdr_offset >= ipte_pkg::OFF_PALETTE && hdr_offset < ipte_pkg::OFF_BITMAP) begin
            // palette words are little endian, alpha forced on unless the word is zero
            if (!hdr_offset[0]) begin
                clut_low = it.data_byte;
            end else begin
                rel  = hdr_offset - ipte_pkg::OFF_PALETTE;
                slot = rel[4:1];
                word = {it.data_byte, clut_low};
                clut[slot] = (word == 16'h0000) ? fill_shadow
                                                : ((word & ipte_pkg::COLOR_MASK) | ipte_pkg::ALPHA_BIT);
            end
        end else if (hdr_offset >= ipte_pkg::OFF_BITMAP) begin
            // one texel pair per bitmap byte, frames tiled left to right
            rel      = hdr_offset - ipte_pkg::OFF_BITMAP;
            idx      = int'(rel[6:3]) * TEX_W + int'(rel[9:7]) * 16 + int'(rel[2:0]) * 2;
            last_off = int'(ipte_pkg::OFF_BITMAP) + int'(hdr_frames) * FRAME_SIZE - 1;
            has             = 1'b1;
            res.texel_even  = clut[it.data_byte[3:0]];
            res.texel_odd   = clut[it.data_byte[7:4]];
            res.texel_index = idx[9:0];
            res.frame_count = hdr_frames;
            res.icon_ok     = 1'b1;
            res.end_of_icon = (int'(hdr_offset) >= last_off);
            if (res.end_of_icon)
                hdr_phase = ipte_pkg::PH_DONE;
            else if (hdr_offset != ipte_pkg::OFFSET_MAX)
                hdr_offset = hdr_offset + 10'd1;
            return;
        end

        if (rejected) begin
            has        = 1'b1;
            res        = REJECT_RES;
            hdr_frames = '0;
            hdr_phase  = ipte_pkg::PH_DONE;
        end else if (hdr_offset != ipte_pkg::OFFSET_MAX) begin
            hdr_offset = hdr_offset + 10'd1;
        end
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50)
            $display("ERROR @%0t: %s", $time, msg);
        mismatch_count++;
    endtask

    task automatic compare_result(input ipte_pkg::t_out got, input ipte_pkg::t_out want);
        if (got.texel_even !== want.texel_even)
            report_mismatch($sformatf("texel_even %h, want %h", got.texel_even, want.texel_even));
        if (got.texel_odd !== want.texel_odd)
            report_mismatch($sformatf("texel_odd %h, want %h", got.texel_odd, want.texel_odd));
        if (got.texel_index !== want.texel_index)
            report_mismatch($sformatf("texel_index %0d, want %0d",
                                      got.texel_index, want.texel_index));
        if (got.frame_count !== want.frame_count)
            report_mismatch($sformatf("frame_count %0d, want %0d",
                                      got.frame_count, want.frame_count));
        if (got.icon_ok !== want.icon_ok)
            report_mismatch($sformatf("icon_ok %b, want %b", got.icon_ok, want.icon_ok));
        if (got.end_of_icon !== want.end_of_icon)
            report_mismatch($sformatf("end_of_icon %b, want %b",
                                      got.end_of_icon, want.end_of_icon));
    endtask

    // offer one byte request and record what it should produce
    task automatic send_byte(input logic [7:0] d, input logic first, input logic [15:0] len,
                             input t_want want);
        ipte_pkg::t_in  item;
        ipte_pkg::t_out res;
        bit             has;
        int             gap;
        item.data_byte     = d;
        item.first_byte    = first;
        item.buffer_length = len;
        gap = pick_wait();
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data  <= item;
        @(posedge i_clk);
        while (in_ch.ready !== 1'b1)
            @(posedge i_clk);
        bytes_sent++;
        decode_header_byte(item, has, res);
        case (want)
            W_PRED:   if (has) icon_results_due.push_back(res);
            W_REJECT: icon_results_due.push_back(REJECT_RES);
            default:  ;
        endcase
    endtask

    // a whole header: magic, flag, title, palette, bitmap, then optional trailing bytes
    task automatic send_icon(input logic [7:0] m0, input logic [7:0] m1, input logic [7:0] flag,
                             input logic [15:0] len, input t_pal_mode pal, input int stop,
                             input int tail);
        logic [15:0] words [16];
        logic [15:0] mix [4];
        logic [7:0]  d;
        int          n_frames;
        int          total;
        int          k;
        mix = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001};
        for (k = 0; k < 16; k++) begin
            case (pal)
                PAL_ZERO: words[k] = 16'h0000;
                PAL_ONES: words[k] = 16'hFFFF;
                PAL_MIX:  words[k] = mix[k % 4];
                default:  words[k] = ($urandom_range(0, 3) == 0) ? 16'h0000
                                                                  : 16'($urandom);
            endcase
        end
        if (flag > ipte_pkg::FLAG_BASE && flag <= ipte_pkg::FLAG_BASE + FRAMES_MAX)
            n_frames = int'(flag - ipte_pkg::FLAG_BASE);
        else
            n_frames = 1;
        total = int'(ipte_pkg::OFF_BITMAP) + n_frames * FRAME_SIZE;
        if (stop > 0 && stop < total)
            total = stop;
        for (int off = 0; off < total + tail; off++) begin
            k = (off - int'(ipte_pkg::OFF_PALETTE)) / 2;
            if (off == 0)
                d = m0;
            else if (off == int'(ipte_pkg::OFF_MAGIC_1))
                d = m1;
            else if (off == int'(ipte_pkg::OFF_FLAG))
                d = flag;
            else if (off >= int'(ipte_pkg::OFF_PALETTE) && off < int'(ipte_pkg::OFF_BITMAP))
                d = (off % 2 == 1) ? words[k][15:8] : words[k][7:0];
            else
                d = 8'($urandom_range(0, 255));
            if (off == 0)
                send_byte(d, 1'b1, len, W_PRED);
            else
                send_byte(d, 1'b0, 16'($urandom_range(0, 65535)), W_PRED);
        end
    endtask

    // sender pause: every result in, then room for a byte that gives none
    task automatic wait_results_drained();
        in_ch.valid <= 1'b0;
        while (icon_results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_fill(input logic [15:0] value);
        ipte_pkg::t_cfg c;
        wait_results_drained();
        c.transparent_fill = value;
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= c;
        @(posedge i_clk);
        while (cfg_ch.ready !== 1'b1)
            @(posedge i_clk);
        cfg_ch.valid <= 1'b0;
        fill_shadow = value;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
            if (icon_results_due.size() == 0)
                report_mismatch($sformatf("result %h with nothing expected", out_ch.data));
            else
                compare_result(out_ch.data, icon_results_due.pop_front());
        end
    end

    // receiver: random stalls per result, one long hold-off on request
    initial begin
        int stall;
        out_ch.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            if (hold_out) begin
                out_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_out = 1'b0;
            end
            stall = pick_wait();
            if (stall > 0) begin
                out_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (out_ch.valid !== 1'b1 && !hold_out)
                @(posedge i_clk);
        end
    end

    // run limit
    initial begin
        #8_000_000;
        $display("Regression FAIL");
        $finish;
    end

    // stimulus
    initial begin
        logic [7:0]  m0;
        logic [7:0]  m1;
        logic [7:0]  flag;
        logic [15:0] len;
        int          stop;
        int          pick;
        in_ch.valid  <= 1'b0;
        in_ch.data   <= '0;
        cfg_ch.valid <= 1'b0;
        cfg_ch.data  <= '0;
        i_rst_n      <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed steps
        foreach (plan[i]) begin
            case (plan[i].kind)
                ROW_BYTE: send_byte(plan[i].d, plan[i].first, plan[i].len, plan[i].want);
                ROW_ICON: send_icon(ipte_pkg::MAGIC_0, ipte_pkg::MAGIC_1, plan[i].d, plan[i].len,
                                    plan[i].pal, int'(plan[i].stop), int'(plan[i].tail));
                default:  write_fill(plan[i].len);
            endcase
        end

        // receiver holds off while a full header streams in
        hold_out = 1'b1;
        steady   = 1'b1;
        send_icon(ipte_pkg::MAGIC_0, ipte_pkg::MAGIC_1, ipte_pkg::FLAG_BASE + 8'd1, 16'hFFFF,
                  PAL_RANDOM, 0, 0);
        steady = 1'b0;
        write_fill(16'($urandom));

        // random headers, mostly well formed
        while (bytes_sent < ITEM_TARGET) begin
            steady = ($urandom_range(0, 3) == 0);
            pick   = $urandom_range(0, 99);
            if (pick < 8) begin
                repeat ($urandom_range(1, 6))
                    send_byte(8'($urandom), 1'b0, 16'($urandom), W_PRED);
            end else if (pick < 14) begin
                send_byte(8'($urandom), 1'b1, 16'($urandom), W_PRED);
            end else if (pick < 30) begin
                m0   = ipte_pkg::MAGIC_0;
                m1   = ipte_pkg::MAGIC_1;
                flag = ipte_pkg::FLAG_BASE + 8'($urandom_range(1, FRAMES_MAX));
                len  = 16'($urandom_range(HDR_BYTES, 65535));
                stop = $urandom_range(1, 8);
                case ($urandom_range(0, 4))
                    0: m0 = 8'($urandom);
                    1: m1 = 8'($urandom);
                    2: flag = 8'($urandom);
                    3: len = 16'($urandom_range(0, HDR_BYTES - 1));
                    default: stop = $urandom_range(9, 300);
                endcase
                send_icon(m0, m1, flag, len, t_pal_mode'($urandom_range(0, 3)), stop, 0);
            end else begin
                len = ($urandom_range(0, 3) == 0) ? 16'(HDR_BYTES)
                                                  : 16'($urandom_range(HDR_BYTES, 65535));
                send_icon(ipte_pkg::MAGIC_0, ipte_pkg::MAGIC_1,
                          ipte_pkg::FLAG_BASE + 8'($urandom_range(1, FRAMES_MAX)), len,
                          t_pal_mode'($urandom_range(0, 3)), 0, $urandom_range(0, 3));
            end
            if ($urandom_range(0, 4) == 0) begin
                case ($urandom_range(0, 3))
                    0: write_fill(16'h0000);
                    1: write_fill(16'hFFFF);
                    default: write_fill(16'($urandom));
                endcase
            end
        end

        steady = 1'b0;
        wait_results_drained();
        repeat (10) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
